>>> design/assert_macros.svh
// Assertion macros for the allocator design files, used by fbfl_back.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising edge, ignored while reset is high
`define FBFL_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Check a property on every rising edge, reset included
`define FBFL_ASSERT_ANY(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

>>> design/fbfl_pkg.sv
// Types and constants of the fixed block free list allocator.
// Used by every module of the block but fbfl_fifo; depends on nothing.
package fbfl_pkg;

  localparam int OFFSET_W  = 20;
  localparam int IDX_W     = 8;
  localparam int SIZE_W    = 13;
  localparam int CFG_IDX_W = 1;
  localparam int DIV_STEPS = 20;
  localparam int DIV_CNT_W = 5;

  localparam logic [SIZE_W-1:0] SIZE_CAP   = 13'd4096;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE  = 1'b1;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_CHECK = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_FULL       = 2'd1,
    ST_RANGE      = 2'd2,
    ST_MISALIGNED = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_LINK,
    S_COMMIT,
    S_DONE
  } state_t;

  typedef struct packed {
    op_t                 op;
    logic [OFFSET_W-1:0] offset;
  } cmd_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] block_offset;
    status_t             status;
    logic                in_pool;
    logic [IDX_W-1:0]    free_count;
    logic                pool_full;
    logic                pool_empty;
  } res_t;

  // Effective configuration handed from the register file to the back end
  typedef struct packed {
    logic [IDX_W-1:0]    count;
    logic [SIZE_W-1:0]   size;
    logic [OFFSET_W-1:0] last;
    logic                init;
  } cfg_t;

endpackage

>>> design/fbfl_fifo.sv
// Small synchronous word queue, used between front and back and for results.
// Depends on nothing; DEPTH must be at least 2.
module fbfl_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] cnt;
  logic             do_wr;
  logic             do_rd;

  assign full    = (cnt == CNT_W'(DEPTH));
  assign empty   = (cnt == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = mem[rd_ptr];

  // Store the incoming word
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        cnt <= cnt + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        cnt <= cnt - CNT_W'(1);
      end
    end
  end

endmodule

>>> design/fbfl_cfg.sv
// Configuration registers: clamps block count and size, works out the last
// block offset and raises a pool init pulse. Depends on fbfl_pkg.
module fbfl_cfg #(
  parameter int MAX_BLOCKS = 255
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [fbfl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fbfl_pkg::SIZE_W-1:0]    cfg_data,
  output fbfl_pkg::cfg_t                cfg
);

  localparam logic [fbfl_pkg::IDX_W-1:0] COUNT_MAX = fbfl_pkg::IDX_W'(MAX_BLOCKS);
  localparam logic [fbfl_pkg::OFFSET_W-1:0] LAST_RESET =
    fbfl_pkg::OFFSET_W'((MAX_BLOCKS - 1) * 16);

  logic [fbfl_pkg::IDX_W-1:0]    count_in;
  logic [fbfl_pkg::SIZE_W-1:0]   size_in;
  logic [fbfl_pkg::IDX_W-1:0]    count_next;
  logic [fbfl_pkg::SIZE_W-1:0]   size_next;
  logic [fbfl_pkg::OFFSET_W-1:0] last_next;

  // Clamp the written value into the legal range
  always_comb begin
    count_in = cfg_data[fbfl_pkg::IDX_W-1:0];
    if (count_in == '0) begin
      count_in = fbfl_pkg::IDX_W'(1);
    end else if (count_in > COUNT_MAX) begin
      count_in = COUNT_MAX;
    end
    size_in = cfg_data;
    if (size_in == '0) begin
      size_in = fbfl_pkg::SIZE_W'(1);
    end else if (size_in > fbfl_pkg::SIZE_CAP) begin
      size_in = fbfl_pkg::SIZE_CAP;
    end
  end

  // Pick the new pair and multiply out the last block offset
  always_comb begin
    count_next = cfg.count;
    size_next  = cfg.size;
    case (cfg_index)
      fbfl_pkg::REG_COUNT: count_next = count_in;
      fbfl_pkg::REG_SIZE:  size_next  = size_in;
      default: ;
    endcase
    last_next = fbfl_pkg::OFFSET_W'(21'(count_next - fbfl_pkg::IDX_W'(1)) * 21'(size_next));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.count <= COUNT_MAX;
      cfg.size  <= fbfl_pkg::SIZE_RESET;
      cfg.last  <= LAST_RESET;
      cfg.init  <= 1'b1;
    end else begin
      cfg.init <= cfg_we;
      if (cfg_we) begin
        cfg.count <= count_next;
        cfg.size  <= size_next;
        cfg.last  <= last_next;
      end
    end
  end

endmodule

>>> design/fbfl_front.sv
// Front end: takes input words, classifies the action and queues a command.
// Depends on fbfl_pkg.
module fbfl_front (
  input  logic                         push,
  output logic                         full,
  input  logic [1:0]                   action,
  input  logic [fbfl_pkg::OFFSET_W-1:0] offset,
  output logic                         cmd_push,
  output fbfl_pkg::cmd_t               cmd,
  input  logic                         cmd_full
);

  assign full     = cmd_full;
  assign cmd_push = push && !cmd_full;

  // Decode the action; an allocate carries no offset
  always_comb begin
    cmd.offset = offset;
    case (action)
      fbfl_pkg::OP_ALLOC: begin
        cmd.op     = fbfl_pkg::OP_ALLOC;
        cmd.offset = '0;
      end
      fbfl_pkg::OP_FREE:  cmd.op = fbfl_pkg::OP_FREE;
      fbfl_pkg::OP_CHECK: cmd.op = fbfl_pkg::OP_CHECK;
      default:            cmd.op = fbfl_pkg::OP_NONE;
    endcase
  end

endmodule

>>> design/fbfl_back.sv
// Back end: runs one command at a time against the free list, link memory
// and serial divider. Depends on fbfl_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fbfl_back #(
  parameter int MAX_BLOCKS = 255
) (
  input  logic           clk,
  input  logic           rst,
  input  fbfl_pkg::cfg_t cfg,
  input  logic           cmd_valid,
  input  fbfl_pkg::cmd_t cmd,
  output logic           cmd_pop,
  input  logic           res_full,
  output logic           res_push,
  output fbfl_pkg::res_t res
);

  localparam int ADDR_W = $clog2(MAX_BLOCKS);

  fbfl_pkg::state_t  state;
  fbfl_pkg::state_t  state_next;
  fbfl_pkg::status_t status;

  logic [fbfl_pkg::IDX_W-1:0]     head;
  logic [fbfl_pkg::IDX_W-1:0]     free_blocks;
  logic [fbfl_pkg::OFFSET_W-1:0]  blk;
  logic                           in_pool;
  logic [fbfl_pkg::SIZE_W-1:0]    rem;
  logic [fbfl_pkg::OFFSET_W-1:0]  quo;
  logic [fbfl_pkg::DIV_CNT_W-1:0] div_cnt;

  logic [fbfl_pkg::IDX_W-1:0] link_mem [MAX_BLOCKS];
  logic                       link_ok  [MAX_BLOCKS];
  logic [fbfl_pkg::IDX_W-1:0] link_rd;
  logic                       link_rd_ok;
  logic [fbfl_pkg::IDX_W-1:0] link_val;
  logic                       link_we;

  logic                         alloc_fail;
  logic                         range_bad;
  logic [fbfl_pkg::SIZE_W:0]    div_shift;
  logic                         div_ge;
  logic [fbfl_pkg::SIZE_W-1:0]  rem_next;

  assign alloc_fail = (free_blocks == '0) || (head >= cfg.count);
  assign range_bad  = (cmd.offset > cfg.last);

  // One restoring division step: shift in the next dividend bit
  assign div_shift = {rem, quo[fbfl_pkg::OFFSET_W-1]};
  assign div_ge    = (div_shift >= {1'b0, cfg.size});
  assign rem_next  = div_ge ? fbfl_pkg::SIZE_W'(div_shift - {1'b0, cfg.size})
                            : div_shift[fbfl_pkg::SIZE_W-1:0];

  // An entry never written since init links to the next block
  assign link_val = link_rd_ok ? link_rd : head + fbfl_pkg::IDX_W'(1);
  assign link_we  = (state == fbfl_pkg::S_COMMIT) && (rem == '0);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      fbfl_pkg::S_IDLE: begin
        if (!cfg.init && cmd_valid) begin
          case (cmd.op)
            fbfl_pkg::OP_ALLOC:
              state_next = alloc_fail ? fbfl_pkg::S_DONE : fbfl_pkg::S_LINK;
            fbfl_pkg::OP_FREE:
              state_next = range_bad ? fbfl_pkg::S_DONE : fbfl_pkg::S_DIV;
            default:
              state_next = fbfl_pkg::S_DONE;
          endcase
        end
      end
      fbfl_pkg::S_DIV: begin
        if (div_cnt == '0) begin
          state_next = fbfl_pkg::S_COMMIT;
        end
      end
      fbfl_pkg::S_LINK:   state_next = fbfl_pkg::S_DONE;
      fbfl_pkg::S_COMMIT: state_next = fbfl_pkg::S_DONE;
      fbfl_pkg::S_DONE: begin
        if (!res_full) begin
          state_next = fbfl_pkg::S_IDLE;
        end
      end
      default: state_next = fbfl_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_pop  = (state == fbfl_pkg::S_IDLE) && !cfg.init && cmd_valid;
    res_push = (state == fbfl_pkg::S_DONE) && !res_full;
    res.block_offset = blk;
    res.status       = status;
    res.in_pool      = in_pool;
    res.free_count   = free_blocks;
    res.pool_full    = (free_blocks == '0);
    res.pool_empty   = (free_blocks == cfg.count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fbfl_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Link memory: write on free commit, read at the head every cycle
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[quo[ADDR_W-1:0]] <= head;
    end
    link_rd <= link_mem[head[ADDR_W-1:0]];
  end

  // Written marks, dropped on reset and pool init
  always_ff @(posedge clk) begin
    if (rst || cfg.init) begin
      for (int i = 0; i < MAX_BLOCKS; i++) begin
        link_ok[i] <= 1'b0;
      end
      link_rd_ok <= 1'b0;
    end else begin
      if (link_we) begin
        link_ok[quo[ADDR_W-1:0]] <= 1'b1;
      end
      link_rd_ok <= link_ok[head[ADDR_W-1:0]];
    end
  end

  // Free list head and count
  always_ff @(posedge clk) begin
    if (rst) begin
      head        <= '0;
      free_blocks <= '0;
    end else if (cfg.init) begin
      head        <= '0;
      free_blocks <= cfg.count;
    end else if (state == fbfl_pkg::S_LINK) begin
      head        <= link_val;
      free_blocks <= free_blocks - fbfl_pkg::IDX_W'(1);
    end else if (link_we) begin
      head <= quo[fbfl_pkg::IDX_W-1:0];
      if (free_blocks != '1) begin
        free_blocks <= free_blocks + fbfl_pkg::IDX_W'(1);
      end
    end
  end

  // Result fields and divider
  always_ff @(posedge clk) begin
    case (state)
      fbfl_pkg::S_IDLE: begin
        if (cmd_pop) begin
          blk     <= '0;
          status  <= fbfl_pkg::ST_OK;
          in_pool <= 1'b0;
          rem     <= '0;
          quo     <= cmd.offset;
          div_cnt <= fbfl_pkg::DIV_CNT_W'(fbfl_pkg::DIV_STEPS - 1);
          case (cmd.op)
            fbfl_pkg::OP_ALLOC: begin
              if (alloc_fail) begin
                status <= fbfl_pkg::ST_FULL;
              end
            end
            fbfl_pkg::OP_FREE: begin
              if (range_bad) begin
                status <= fbfl_pkg::ST_RANGE;
              end
            end
            fbfl_pkg::OP_CHECK: in_pool <= !range_bad;
            default: ;
          endcase
        end
      end
      fbfl_pkg::S_DIV: begin
        rem     <= rem_next;
        quo     <= {quo[fbfl_pkg::OFFSET_W-2:0], div_ge};
        div_cnt <= div_cnt - fbfl_pkg::DIV_CNT_W'(1);
      end
      fbfl_pkg::S_LINK: begin
        blk <= fbfl_pkg::OFFSET_W'(21'(head) * 21'(cfg.size));
      end
      fbfl_pkg::S_COMMIT: begin
        if (rem != '0) begin
          status <= fbfl_pkg::ST_MISALIGNED;
        end
      end
      default: ;
    endcase
  end

  `FBFL_ASSERT(a_pop_leaves_idle, clk, rst, cmd_pop |=> (state != fbfl_pkg::S_IDLE),
    "command taken but back end stayed idle")
  `FBFL_ASSERT(a_link_has_block, clk, rst,
    (state == fbfl_pkg::S_LINK) |-> (free_blocks != '0 && head < cfg.count),
    "allocation entered with no usable block")
  `FBFL_ASSERT(a_commit_in_pool, clk, rst,
    (state == fbfl_pkg::S_COMMIT && rem == '0) |->
      (quo < fbfl_pkg::OFFSET_W'(cfg.count)),
    "freed block index beyond block count")
  `FBFL_ASSERT(a_init_resets_list, clk, rst,
    cfg.init |=> (head == '0 && free_blocks == $past(cfg.count)),
    "pool init did not restore the free list")
  `FBFL_ASSERT_ANY(a_no_pop_after_reset, clk, rst |=> !cmd_pop,
    "command taken before pool init")

endmodule

>>> design/fixed_block_free_list_allocator.sv
// Back end path: IDLE to DONE for a check, no-op, rejected free or failed
// allocate; via LINK for an allocate; via DIV (bit-serial offset divider) and
// COMMIT for a free. One command runs there at a time, held in DONE while the
// result queue is full. Two-word queues sit on input and result side.
// Synchronous reset empties both queues and the first cycle after it
// reinitialises the free list: 255 blocks of 16 bytes (clamped to MAX_BLOCKS).
// Top level: config registers, front end, command and result queues, back end.
module fixed_block_free_list_allocator #(
  parameter int MAX_BLOCKS = 255
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic [1:0]                     action,
  input  logic [fbfl_pkg::OFFSET_W-1:0]  offset,
  output logic                           empty,
  input  logic                           pop,
  output logic [fbfl_pkg::OFFSET_W-1:0]  block_offset,
  output logic [1:0]                     status,
  output logic                           in_pool,
  output logic [fbfl_pkg::IDX_W-1:0]     free_count,
  output logic                           pool_full,
  output logic                           pool_empty,
  input  logic                           cfg_we,
  input  logic [fbfl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fbfl_pkg::SIZE_W-1:0]    cfg_data
);

  localparam int CMD_W = $bits(fbfl_pkg::cmd_t);
  localparam int RES_W = $bits(fbfl_pkg::res_t);

  fbfl_pkg::cfg_t cfg;
  fbfl_pkg::cmd_t cmd_in;
  fbfl_pkg::cmd_t cmd_out;
  fbfl_pkg::res_t res_in;
  fbfl_pkg::res_t res_out;

  logic             cmd_push;
  logic             cmd_full;
  logic             cmd_empty;
  logic             cmd_pop;
  logic             res_push;
  logic             res_full;
  logic [CMD_W-1:0] cmd_word;
  logic [RES_W-1:0] res_word;

  fbfl_cfg #(.MAX_BLOCKS(MAX_BLOCKS)) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  fbfl_front u_front (
    .push     (push),
    .full     (full),
    .action   (action),
    .offset   (offset),
    .cmd_push (cmd_push),
    .cmd      (cmd_in),
    .cmd_full (cmd_full)
  );

  fbfl_fifo #(.WIDTH(CMD_W), .DEPTH(2)) u_cmd_q (
    .clk     (clk),
    .rst     (rst),
    .wr      (cmd_push),
    .wr_data (cmd_in),
    .full    (cmd_full),
    .rd      (cmd_pop),
    .rd_data (cmd_word),
    .empty   (cmd_empty)
  );

  assign cmd_out = fbfl_pkg::cmd_t'(cmd_word);

  fbfl_back #(.MAX_BLOCKS(MAX_BLOCKS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (!cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  fbfl_fifo #(.WIDTH(RES_W), .DEPTH(2)) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr      (res_push),
    .wr_data (res_in),
    .full    (res_full),
    .rd      (pop),
    .rd_data (res_word),
    .empty   (empty)
  );

  // Unpack the oldest result onto the ports
  assign res_out      = fbfl_pkg::res_t'(res_word);
  assign block_offset = res_out.block_offset;
  assign status       = res_out.status;
  assign in_pool      = res_out.in_pool;
  assign free_count   = res_out.free_count;
  assign pool_full    = res_out.pool_full;
  assign pool_empty   = res_out.pool_empty;

endmodule

>>> tb/fixed_block_free_list_allocator_tb.sv
// Self-checking testbench for the fixed block free list allocator.
// Predicts every result word with a behavioural copy of the free list and
// compares it field by field. Depends only on fbfl_pkg and the block.
`timescale 1ns / 1ps

module fixed_block_free_list_allocator_tb;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned SETTLE_CYCLES = 30;
  localparam int unsigned WORDS_PER_PHASE = 150;

  // Shadow of the pool: free list, counters, registers and pending result words
  class pool_scoreboard;
    logic [fbfl_pkg::IDX_W-1:0]    link [255];
    int unsigned                   head;
    int unsigned                   free_blocks;
    logic [7:0]                    count_reg;
    logic [fbfl_pkg::SIZE_W-1:0]   size_reg;
    fbfl_pkg::res_t                expected_words [$];
    logic [fbfl_pkg::OFFSET_W-1:0] live_offsets [$];
    int                            errors;

    function new();
      count_reg = 8'd255;
      size_reg = fbfl_pkg::SIZE_RESET;
      errors = 0;
      init_pool();
    endfunction

    function int unsigned eff_count();
      return (count_reg == 8'd0) ? 1 : count_reg;
    endfunction

    function int unsigned eff_size();
      if (size_reg == '0) return 1;
      if (size_reg > fbfl_pkg::SIZE_CAP) return fbfl_pkg::SIZE_CAP;
      return size_reg;
    endfunction

    function int unsigned last_offset();
      return (eff_count() - 1) * eff_size();
    endfunction

    // Chain every block to the next and mark them all free
    function void init_pool();
      for (int i = 0; i < 255; i++) link[i] = fbfl_pkg::IDX_W'(i + 1);
      head = 0;
      free_blocks = eff_count();
      live_offsets.delete();
    endfunction

    // Any register write reinitialises the pool
    function void write_reg(logic [fbfl_pkg::CFG_IDX_W-1:0] idx,
                            logic [fbfl_pkg::SIZE_W-1:0] data);
      if (idx == fbfl_pkg::REG_COUNT) count_reg = data[7:0];
      else size_reg = data;
      init_pool();
    endfunction

    // Predict the result word of one accepted command and advance the list
    function void note_word(fbfl_pkg::op_t op, logic [fbfl_pkg::OFFSET_W-1:0] off);
      fbfl_pkg::res_t want;
      int unsigned    cnt;
      int unsigned    sz;
      int unsigned    last;
      int unsigned    idx;
      want = '0;
      cnt = eff_count();
      sz = eff_size();
      last = last_offset();
      case (op)
        fbfl_pkg::OP_ALLOC: begin
          if (free_blocks == 0 || head >= cnt) begin
            want.status = fbfl_pkg::ST_FULL;
          end else begin
            want.block_offset = fbfl_pkg::OFFSET_W'(head * sz);
            live_offsets = {live_offsets, fbfl_pkg::OFFSET_W'(head * sz)};
            head = link[head];
            free_blocks--;
          end
        end
        fbfl_pkg::OP_FREE: begin
          if (off > last) begin
            want.status = fbfl_pkg::ST_RANGE;
          end else if (off % sz != 0) begin
            want.status = fbfl_pkg::ST_MISALIGNED;
          end else begin
            idx = off / sz;
            link[idx] = fbfl_pkg::IDX_W'(head);
            head = idx;
            if (free_blocks < 255) free_blocks++;
            for (int i = 0; i < live_offsets.size(); i++) begin
              if (live_offsets[i] == off) begin
                live_offsets.delete(i);
                break;
              end
            end
          end
        end
        fbfl_pkg::OP_CHECK: begin
          want.in_pool = (off <= last);
        end
        default: begin
        end
      endcase
      want.free_count = fbfl_pkg::IDX_W'(free_blocks);
      want.pool_full = (free_blocks == 0);
      want.pool_empty = (free_blocks == cnt);
      expected_words = {expected_words, want};
    endfunction

    function int field_differs(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        return 1;
      end
      return 0;
    endfunction

    // Compare one popped result word with the oldest prediction
    function void check_word(fbfl_pkg::res_t got);
      fbfl_pkg::res_t want;
      if (expected_words.size() == 0) begin
        $display("%0t: result word with nothing expected, block_offset %0d status %0d",
                 $time, got.block_offset, got.status);
        errors++;
        return;
      end
      want = expected_words.pop_front();
      errors += field_differs("block_offset", want.block_offset, got.block_offset);
      errors += field_differs("status", want.status, got.status);
      errors += field_differs("in_pool", want.in_pool, got.in_pool);
      errors += field_differs("free_count", want.free_count, got.free_count);
      errors += field_differs("pool_full", want.pool_full, got.pool_full);
      errors += field_differs("pool_empty", want.pool_empty, got.pool_empty);
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           push = 1'b0;
  logic                           full;
  logic [1:0]                     action = '0;
  logic [fbfl_pkg::OFFSET_W-1:0]  offset = '0;
  logic                           empty;
  logic                           pop = 1'b0;
  logic [fbfl_pkg::OFFSET_W-1:0]  block_offset;
  logic [1:0]                     status;
  logic                           in_pool;
  logic [fbfl_pkg::IDX_W-1:0]     free_count;
  logic                           pool_full;
  logic                           pool_empty;
  logic                           cfg_we = 1'b0;
  logic [fbfl_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [fbfl_pkg::SIZE_W-1:0]    cfg_data = '0;

  bit                             no_gaps = 1'b0;
  int unsigned                    cycle_count = 0;
  pool_scoreboard                 sb;

  fixed_block_free_list_allocator i_dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .action       (action),
    .offset       (offset),
    .empty        (empty),
    .pop          (pop),
    .block_offset (block_offset),
    .status       (status),
    .in_pool      (in_pool),
    .free_count   (free_count),
    .pool_full    (pool_full),
    .pool_empty   (pool_empty),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Check each popped word, then decide whether to stall the next one
  always @(posedge clk) begin : result_side
    fbfl_pkg::res_t got;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        got.block_offset = block_offset;
        got.status = fbfl_pkg::status_t'(status);
        got.in_pool = in_pool;
        got.free_count = free_count;
        got.pool_full = pool_full;
        got.pool_empty = pool_empty;
        sb.check_word(got);
      end
      pop <= no_gaps || ($urandom_range(0, 99) >= 33);
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("fixed_block_free_list_allocator_tb: errors");
      $finish;
    end
  end

  // Offer one command word, idling first at random, and hold it until taken
  task automatic send_word(fbfl_pkg::op_t op, logic [fbfl_pkg::OFFSET_W-1:0] off);
    while (!no_gaps && $urandom_range(0, 99) < 33) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    action <= op;
    offset <= off;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_word(op, off);
  endtask

  // Drop push and wait until every predicted word has been popped
  task automatic settle();
    push <= 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both registers back to back; the block must be idle
  task automatic write_pool_cfg(logic [fbfl_pkg::SIZE_W-1:0] count_data,
                                logic [fbfl_pkg::SIZE_W-1:0] size_data);
    cfg_we <= 1'b1;
    cfg_index <= fbfl_pkg::REG_COUNT;
    cfg_data <= count_data;
    @(posedge clk);
    sb.write_reg(fbfl_pkg::REG_COUNT, count_data);
    cfg_index <= fbfl_pkg::REG_SIZE;
    cfg_data <= size_data;
    @(posedge clk);
    sb.write_reg(fbfl_pkg::REG_SIZE, size_data);
    cfg_we <= 1'b0;
  endtask

  // Mostly allocate and free live blocks, with double frees, bad offsets and checks
  task automatic random_word(output fbfl_pkg::op_t op,
                             output logic [fbfl_pkg::OFFSET_W-1:0] off);
    int unsigned pick;
    int unsigned cnt;
    int unsigned sz;
    int unsigned last;
    pick = $urandom_range(0, 99);
    cnt = sb.eff_count();
    sz = sb.eff_size();
    last = sb.last_offset();
    off = fbfl_pkg::OFFSET_W'($urandom);
    if (pick < 40) begin
      op = fbfl_pkg::OP_ALLOC;
    end else if (pick < 65 && sb.live_offsets.size() != 0) begin
      op = fbfl_pkg::OP_FREE;
      off = sb.live_offsets[$urandom_range(0, sb.live_offsets.size() - 1)];
    end else if (pick < 72) begin
      op = fbfl_pkg::OP_FREE;
      off = fbfl_pkg::OFFSET_W'($urandom_range(0, cnt - 1) * sz);
    end else if (pick < 80) begin
      op = fbfl_pkg::OP_FREE;
      if ($urandom_range(0, 1) == 1) off = fbfl_pkg::OFFSET_W'($urandom_range(0, last + sz));
    end else if (pick < 95) begin
      op = fbfl_pkg::OP_CHECK;
      case ($urandom_range(0, 2))
        0: off = fbfl_pkg::OFFSET_W'($urandom_range(0, last));
        1: off = fbfl_pkg::OFFSET_W'(last + $urandom_range(0, 1));
        default: begin
        end
      endcase
    end else begin
      op = fbfl_pkg::OP_NONE;
    end
  endtask

  initial begin
    fbfl_pkg::op_t                 op;
    logic [fbfl_pkg::OFFSET_W-1:0] off;
    logic [fbfl_pkg::SIZE_W-1:0]   count_data;
    logic [fbfl_pkg::SIZE_W-1:0]   size_data;
    int unsigned                   sent;

    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    // let the pool init after reset pass
    repeat (5) @(posedge clk);

    // Reset configuration: 255 blocks of 16 bytes, last block at 4064
    send_word(fbfl_pkg::OP_CHECK, 20'd0);
    send_word(fbfl_pkg::OP_CHECK, 20'd4064);
    send_word(fbfl_pkg::OP_CHECK, 20'd4065);
    send_word(fbfl_pkg::OP_CHECK, 20'hFFFFF);
    send_word(fbfl_pkg::OP_FREE, 20'd0);       // double free while the count sits at its ceiling
    send_word(fbfl_pkg::OP_FREE, 20'd4065);    // just past the last block
    send_word(fbfl_pkg::OP_FREE, 20'd4063);    // in range but misaligned
    send_word(fbfl_pkg::OP_FREE, 20'hFFFFF);
    send_word(fbfl_pkg::OP_ALLOC, fbfl_pkg::OFFSET_W'($urandom));
    send_word(fbfl_pkg::OP_ALLOC, 20'hFFFFF);
    send_word(fbfl_pkg::OP_FREE, 20'd16);
    send_word(fbfl_pkg::OP_NONE, 20'hFFFFF);
    send_word(fbfl_pkg::OP_ALLOC, 20'd0);
    settle();

    // Zero in both registers clamps to one block of one byte
    write_pool_cfg('0, '0);
    send_word(fbfl_pkg::OP_ALLOC, 20'd0);
    send_word(fbfl_pkg::OP_ALLOC, 20'd0);      // pool full
    send_word(fbfl_pkg::OP_FREE, 20'd1);
    send_word(fbfl_pkg::OP_FREE, 20'd0);
    send_word(fbfl_pkg::OP_CHECK, 20'd0);
    send_word(fbfl_pkg::OP_CHECK, 20'd1);
    settle();

    // Oversized block size clamps to 4096
    write_pool_cfg(13'd255, 13'h1FFF);
    send_word(fbfl_pkg::OP_CHECK, 20'd1040384);
    send_word(fbfl_pkg::OP_FREE, 20'd1040384);
    send_word(fbfl_pkg::OP_FREE, 20'd1040385);
    send_word(fbfl_pkg::OP_FREE, 20'd4095);
    send_word(fbfl_pkg::OP_ALLOC, 20'd0);
    settle();

    // Random phases, each under its own configuration
    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0: begin
          count_data = 13'h1F05;
          size_data = 13'h1FFF;
        end
        1: begin
          count_data = 13'd255;
          size_data = 13'd1;
        end
        2: begin
          count_data = 13'd3;
          size_data = 13'd24;
        end
        3: begin
          count_data = 13'd255;
          size_data = 13'd4096;
        end
        4: begin
          count_data = 13'd0;
          size_data = 13'd0;
        end
        9: begin
          count_data = fbfl_pkg::SIZE_W'($urandom_range(17, 255));
          size_data = fbfl_pkg::SIZE_W'($urandom_range(1, 8191));
        end
        default: begin
          count_data = fbfl_pkg::SIZE_W'($urandom_range(1, 16));
          case ($urandom_range(0, 3))
            0: size_data = fbfl_pkg::SIZE_W'($urandom_range(1, 4));
            1: size_data = fbfl_pkg::SIZE_W'($urandom_range(1, 64));
            2: size_data = 13'd4096;
            default: size_data = fbfl_pkg::SIZE_W'($urandom_range(1, 8191));
          endcase
        end
      endcase
      // one phase runs both sides flat out
      no_gaps = (phase == 1);
      write_pool_cfg(count_data, size_data);
      sent = 0;
      while (sent < WORDS_PER_PHASE) begin
        random_word(op, off);
        send_word(op, off);
        if (op != fbfl_pkg::OP_NONE) begin
          sent++;
          // hold the sender once until the result side has caught up
          if (phase == 2 && sent == WORDS_PER_PHASE / 2) settle();
        end
      end
      settle();
    end
    no_gaps = 1'b0;

    if (sb.errors == 0) begin
      $display("fixed_block_free_list_allocator_tb: clean");
    end else begin
      $display("fixed_block_free_list_allocator_tb: errors");
    end
    $finish;
  end

endmodule
